// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define CTI_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cti assertion failed");

// clocked property, checked in every cycle
`define CTI_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("cti assertion failed");

`endif

// ===== design/cti_pkg.sv =====
// shared types and constants of the calibration table interpolator
`timescale 1ns / 1ps
package cti_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int SLOT_COUNT      = 64;
   localparam int KEY_W           = 32;
   localparam int VAL_W           = 16;
   localparam int CNT_W           = 7;
   localparam int SLOT_W          = 6;
   localparam int DIVIDEND_W      = 48;
   localparam int DIVISOR_W       = 32;
   localparam int QUOT_W          = 16;
   localparam int STEP_W          = 4;
   localparam logic [VAL_W-1:0]     T_FULL   = 16'hFFFF;
   localparam logic [CNT_W-1:0]     COUNT_RESET = 7'd1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_PREP, ST_DECIDE, ST_RATIO, ST_MIX_A, ST_MIX_B, ST_NORM
   } state_type;

   // bracket found so far, handed from cell to cell
   typedef struct packed {
      logic                    found;
      logic signed [KEY_W-1:0] lo_key;
      logic [VAL_W-1:0]        lo_val;
      logic signed [KEY_W-1:0] hi_key;
      logic [VAL_W-1:0]        hi_val;
   } token_type;

   // entry write broadcast to all cells
   typedef struct packed {
      logic                    write;
      logic [SLOT_W-1:0]       slot;
      logic signed [KEY_W-1:0] key;
      logic [VAL_W-1:0]        first;
      logic [VAL_W-1:0]        second;
   } load_type;

   // lookup context broadcast to all cells
   typedef struct packed {
      logic                    channel;
      logic signed [KEY_W-1:0] query;
      logic [CNT_W-1:0]        count;
   } scan_type;
endpackage

// ===== design/cti_cell.sv =====
// one table entry plus one stage of the bracket search
`timescale 1ns / 1ps
module cti_cell #(
   parameter int DEPTH = cti_pkg::TABLE_DEPTH_DEF,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cti_pkg::load_type  load,
   input  cti_pkg::scan_type  scan,
   input  logic               tok_valid,
   input  cti_pkg::token_type tok,
   output logic               tok_valid_out,
   output cti_pkg::token_type tok_out
);
   logic signed [cti_pkg::KEY_W-1:0] key_ff;
   logic [cti_pkg::VAL_W-1:0]        first_ff;
   logic [cti_pkg::VAL_W-1:0]        second_ff;
   logic                             valid_ff;
   cti_pkg::token_type               tok_ff;
   cti_pkg::token_type               tok_in;
   logic                             hit;
   logic                             active;
   logic [cti_pkg::VAL_W-1:0]        own_val;

   // slot decode: load index wraps modulo the table depth
   always_comb begin
      hit = 1'b0;
      for (int m = 0; m < cti_pkg::SLOT_COUNT; m++) begin
         if (m * DEPTH + IDX < cti_pkg::SLOT_COUNT) begin
            hit = hit | (load.slot == cti_pkg::SLOT_W'(m * DEPTH + IDX));
         end
      end
   end

   // bracket update for this entry
   always_comb begin
      own_val = scan.channel ? second_ff : first_ff;
      active  = ({25'b0, scan.count} > 32'(IDX));
      tok_in  = tok;
      if (IDX == 0) begin
         tok_in.found  = 1'b0;
         tok_in.lo_key = key_ff;
         tok_in.lo_val = own_val;
      end
      if (active && !tok_in.found) begin
         if (key_ff <= scan.query) begin
            if (key_ff >= tok_in.lo_key) begin
               tok_in.lo_key = key_ff;
               tok_in.lo_val = own_val;
            end
         end else begin
            tok_in.found  = 1'b1;
            tok_in.hi_key = key_ff;
            tok_in.hi_val = own_val;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (load.write && hit) begin
         key_ff    <= load.key;
         first_ff  <= load.first;
         second_ff <= load.second;
      end
   end

   // hand the word on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_valid;
      end
      tok_ff <= tok_in;
   end

   assign tok_valid_out = valid_ff;
   assign tok_out       = tok_ff;
endmodule

// ===== design/cti_div.sv =====
// restoring divider, one quotient bit per cycle, 16-bit quotient
`timescale 1ns / 1ps
module cti_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic [cti_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [cti_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [cti_pkg::QUOT_W-1:0]      quotient
);
   logic [cti_pkg::DIVISOR_W-1:0] rem_ff;
   logic [cti_pkg::QUOT_W-1:0]    low_ff;
   logic [cti_pkg::QUOT_W-1:0]    quo_ff;
   logic [cti_pkg::DIVISOR_W-1:0] dsr_ff;
   logic [cti_pkg::STEP_W-1:0]    cnt_ff;
   logic                          run_ff;
   logic                          done_ff;
   logic [cti_pkg::DIVISOR_W:0]   trial;
   logic [cti_pkg::DIVISOR_W:0]   diff;
   logic                          ge;

   // trial subtract of the next bit
   always_comb begin
      trial = {rem_ff, low_ff[cti_pkg::QUOT_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
   end

   // datapath
   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= dividend[cti_pkg::DIVIDEND_W-1:cti_pkg::QUOT_W];
         low_ff <= dividend[cti_pkg::QUOT_W-1:0];
         dsr_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[cti_pkg::DIVISOR_W-1:0] : trial[cti_pkg::DIVISOR_W-1:0];
         low_ff <= {low_ff[cti_pkg::QUOT_W-2:0], 1'b0};
         quo_ff <= {quo_ff[cti_pkg::QUOT_W-2:0], ge};
      end
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == {cti_pkg::STEP_W{1'b1}}) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== design/calibration_table_interpolator.sv =====
// top level: cell row for the bracket search, then ratio and mix arithmetic
// a lookup runs through the cell row, then states PREP and DECIDE, the 16-step divide (skipped when the
// ratio needs no divide), MIX_A, MIX_B and NORM; rsp_strobe is registered from NORM
// one lookup at a time, busy high throughout
// a load raises no busy; rsp_strobe lasts one cycle, receiver cannot stall
// synchronous reset clears control and sets entries_in_use to 1; table undefined
`timescale 1ns / 1ps
module calibration_table_interpolator #(
   parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [cti_pkg::SLOT_W-1:0]          req_entry_index,
   input  logic signed [cti_pkg::KEY_W-1:0]    req_entry_key,
   input  logic [cti_pkg::VAL_W-1:0]           req_entry_value_first,
   input  logic [cti_pkg::VAL_W-1:0]           req_entry_value_second,
   input  logic                                req_channel,
   input  logic signed [cti_pkg::KEY_W-1:0]    req_query_key,
   output logic                                rsp_strobe,
   output logic [cti_pkg::VAL_W-1:0]           rsp_interpolated_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cti_pkg::CNT_W-1:0]           csr_data
);
   cti_pkg::state_type               state_ff, state_in;
   logic [cti_pkg::CNT_W-1:0]        count_ff;
   logic signed [cti_pkg::KEY_W-1:0] query_ff;
   logic                             channel_ff;
   logic                             go_ff;
   logic signed [cti_pkg::KEY_W-1:0] kl_ff, kh_ff;
   logic [cti_pkg::VAL_W-1:0]        vl_ff, vh_ff;
   logic signed [cti_pkg::KEY_W:0]   num_ff, den_ff;
   logic [cti_pkg::VAL_W-1:0]        t_ff;
   logic [2*cti_pkg::VAL_W-1:0]      prod_ff;
   logic [2*cti_pkg::VAL_W-1:0]      sum_ff;
   logic                             rsp_strobe_ff;
   logic [cti_pkg::VAL_W-1:0]        rsp_value_ff;

   logic                             accept;
   logic                             no_ratio;
   logic                             saturate;
   logic                             div_go;
   logic [cti_pkg::DIVIDEND_W-1:0]   div_dividend;
   logic [cti_pkg::DIVISOR_W-1:0]    div_divisor;
   logic                             div_done;
   logic [cti_pkg::QUOT_W-1:0]       div_quot;
   logic [2*cti_pkg::VAL_W-1:0]      mix_sum;
   logic [2*cti_pkg::VAL_W:0]        norm_sum;
   cti_pkg::load_type                load;
   cti_pkg::scan_type                scan;
   logic                             valid_w [0:TABLE_DEPTH];
   cti_pkg::token_type               tok_w   [0:TABLE_DEPTH];

   assign accept    = start && !busy;
   assign busy      = (state_ff != cti_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // broadcasts to the cell row
   always_comb begin
      load.write  = accept && !req_action;
      load.slot   = req_entry_index;
      load.key    = req_entry_key;
      load.first  = req_entry_value_first;
      load.second = req_entry_value_second;
      scan.channel = channel_ff;
      scan.query   = query_ff;
      scan.count   = count_ff;
   end

   assign valid_w[0] = go_ff;
   assign tok_w[0]   = '0;

   // cell row
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      cti_cell #(.DEPTH(TABLE_DEPTH), .IDX(i)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .load          (load),
         .scan          (scan),
         .tok_valid     (valid_w[i]),
         .tok           (tok_w[i]),
         .tok_valid_out (valid_w[i+1]),
         .tok_out       (tok_w[i+1])
      );
   end

   // divider for the ratio
   cti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ratio cases, mix sum and division by 65535 through the 2^16 reciprocal
   always_comb begin
      no_ratio = den_ff[cti_pkg::KEY_W] || (den_ff == '0) ||
                 num_ff[cti_pkg::KEY_W] || (num_ff == '0);
      saturate = (num_ff[cti_pkg::KEY_W-1:0] >= den_ff[cti_pkg::KEY_W-1:0]);
      mix_sum  = prod_ff + ({16'b0, vh_ff} * {16'b0, t_ff});
      norm_sum = {1'b0, sum_ff} + {17'b0, sum_ff[2*cti_pkg::VAL_W-1:cti_pkg::VAL_W]} +
                 33'd1;
   end

   // next state and divider launch
   always_comb begin
      state_in     = state_ff;
      div_go       = 1'b0;
      div_dividend = {num_ff[cti_pkg::KEY_W-1:0], 16'b0} -
                     {16'b0, num_ff[cti_pkg::KEY_W-1:0]};
      div_divisor  = den_ff[cti_pkg::KEY_W-1:0];
      case (state_ff)
         cti_pkg::ST_IDLE: begin
            if (accept && req_action) state_in = cti_pkg::ST_SCAN;
         end
         cti_pkg::ST_SCAN: begin
            if (valid_w[TABLE_DEPTH]) state_in = cti_pkg::ST_PREP;
         end
         cti_pkg::ST_PREP: begin
            state_in = cti_pkg::ST_DECIDE;
         end
         cti_pkg::ST_DECIDE: begin
            if (no_ratio || saturate) begin
               state_in = cti_pkg::ST_MIX_A;
            end else begin
               div_go   = 1'b1;
               state_in = cti_pkg::ST_RATIO;
            end
         end
         cti_pkg::ST_RATIO: begin
            if (div_done) state_in = cti_pkg::ST_MIX_A;
         end
         cti_pkg::ST_MIX_A: begin
            state_in = cti_pkg::ST_MIX_B;
         end
         cti_pkg::ST_MIX_B: begin
            state_in = cti_pkg::ST_NORM;
         end
         cti_pkg::ST_NORM: begin
            state_in = cti_pkg::ST_IDLE;
         end
         default: begin
            state_in = cti_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cti_pkg::ST_IDLE;
         count_ff      <= cti_pkg::COUNT_RESET;
         go_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= accept && req_action;
         rsp_strobe_ff <= (state_ff == cti_pkg::ST_NORM);
         if (csr_valid && csr_ready) count_ff <= csr_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && req_action) begin
         query_ff   <= req_query_key;
         channel_ff <= req_channel;
      end
      if (state_ff == cti_pkg::ST_SCAN && valid_w[TABLE_DEPTH]) begin
         kl_ff <= tok_w[TABLE_DEPTH].lo_key;
         vl_ff <= tok_w[TABLE_DEPTH].lo_val;
         kh_ff <= tok_w[TABLE_DEPTH].found ? tok_w[TABLE_DEPTH].hi_key
                                           : tok_w[TABLE_DEPTH].lo_key;
         vh_ff <= tok_w[TABLE_DEPTH].found ? tok_w[TABLE_DEPTH].hi_val
                                           : tok_w[TABLE_DEPTH].lo_val;
      end
      if (state_ff == cti_pkg::ST_PREP) begin
         num_ff <= {query_ff[cti_pkg::KEY_W-1], query_ff} - {kl_ff[cti_pkg::KEY_W-1], kl_ff};
         den_ff <= {kh_ff[cti_pkg::KEY_W-1], kh_ff} - {kl_ff[cti_pkg::KEY_W-1], kl_ff};
      end
      if (state_ff == cti_pkg::ST_DECIDE) begin
         t_ff <= (!no_ratio && saturate) ? cti_pkg::T_FULL : '0;
      end
      if (state_ff == cti_pkg::ST_RATIO && div_done) begin
         t_ff <= div_quot;
      end
      if (state_ff == cti_pkg::ST_MIX_A) begin
         prod_ff <= {16'b0, vl_ff} * {16'b0, cti_pkg::T_FULL - t_ff};
      end
      if (state_ff == cti_pkg::ST_MIX_B) begin
         sum_ff <= mix_sum;
      end
      if (state_ff == cti_pkg::ST_NORM) begin
         rsp_value_ff <= norm_sum[2*cti_pkg::VAL_W-1:cti_pkg::VAL_W];
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_interpolated_value = rsp_value_ff;
endmodule

// ===== design/cti_checker.sv =====
// port-level checks of the interpolator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cti_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             req_action,
   input logic                             rsp_strobe,
   input logic [cti_pkg::VAL_W-1:0]        rsp_interpolated_value
);
   // a lookup keeps the block busy
   `CTI_ASSERT_RST(a_lookup_busy, clock, reset, (start && !busy && req_action) |=> busy)
   // each word appears for one cycle only
   `CTI_ASSERT_RST(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   // a word only ends a lookup in progress
   `CTI_ASSERT_RST(a_strobe_after_busy, clock, reset, rsp_strobe |-> $past(busy))
   // a delivered word holds a known value
   `CTI_ASSERT_RST(a_value_known, clock, reset, rsp_strobe |-> !$isunknown(rsp_interpolated_value))
endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (
   .clock                  (clock),
   .reset                  (reset),
   .start                  (start),
   .busy                   (busy),
   .req_action             (req_action),
   .rsp_strobe             (rsp_strobe),
   .rsp_interpolated_value (rsp_interpolated_value)
);
